FILE: rtl/hhpd_pkg.sv
package hhpd_pkg;

   localparam int unsigned GAIN_W    = 16;
   localparam int unsigned DUTY_W    = 16;
   localparam int unsigned TOTAL_W   = 17;
   localparam int unsigned ANGLE_W   = 16;
   localparam int unsigned ERR_W     = 17;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned ELAPSED_W = 31;
   localparam int unsigned PTERM_W   = 25;
   localparam int unsigned DTERM_W   = 24;
   localparam int unsigned CORR_W    = 17;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 17;
   localparam int unsigned PROD_W    = 34;
   localparam int unsigned SUM_W     = PROD_W - 8;

   typedef enum logic [2:0] {
      FUNC_RESET  = 3'd0,
      FUNC_START  = 3'd1,
      FUNC_UPDATE = 3'd2,
      FUNC_STOP   = 3'd3,
      FUNC_DEFER  = 3'd4,
      FUNC_FAULT  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_ACTIVE  = 2'd1,
      MODE_STOPPED = 2'd2,
      MODE_FAULT   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REASON_NONE    = 3'd0,
      REASON_CONFIG  = 3'd1,
      REASON_MEASURE = 3'd2,
      REASON_IMU     = 3'd3,
      REASON_LINK    = 3'd4,
      REASON_COMMAND = 3'd5
   } reason_type;

   typedef enum logic [2:0] {
      CSR_GAIN_P       = 3'd0,
      CSR_GAIN_D       = 3'd1,
      CSR_MAX_YAW      = 3'd2,
      CSR_MAX_STRAFE   = 3'd3,
      CSR_MAX_TOTAL    = 3'd4,
      CSR_YAW_POLARITY = 3'd5
   } csr_index_type;

   localparam logic [1:0] SIGN_POS = 2'b01;
   localparam logic [1:0] SIGN_NEG = 2'b11;

   // Controller settings seen by the datapath
   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_d;
      logic [DUTY_W-1:0] max_yaw;
      logic              ok;
   } cfg_type;

endpackage

FILE: rtl/hhpd_csr.sv
module hhpd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [hhpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hhpd_pkg::CSR_DAT_W-1:0]   csr_data,
   output hhpd_pkg::cfg_type                cfg
);
   import hhpd_pkg::*;

   logic [GAIN_W-1:0]  gain_p_ff;
   logic [GAIN_W-1:0]  gain_d_ff;
   logic [DUTY_W-1:0]  max_yaw_ff;
   logic [DUTY_W-1:0]  max_strafe_ff;
   logic [TOTAL_W-1:0] max_total_ff;
   logic [1:0]         polarity_ff;
   logic [TOTAL_W-1:0] limit_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= GAIN_W'(256);
         gain_d_ff     <= '0;
         max_yaw_ff    <= '0;
         max_strafe_ff <= '0;
         max_total_ff  <= '0;
         polarity_ff   <= SIGN_POS;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:       gain_p_ff     <= csr_data[GAIN_W-1:0];
            CSR_GAIN_D:       gain_d_ff     <= csr_data[GAIN_W-1:0];
            CSR_MAX_YAW:      max_yaw_ff    <= csr_data[DUTY_W-1:0];
            CSR_MAX_STRAFE:   max_strafe_ff <= csr_data[DUTY_W-1:0];
            CSR_MAX_TOTAL:    max_total_ff  <= csr_data[TOTAL_W-1:0];
            CSR_YAW_POLARITY: polarity_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   assign limit_sum = {1'b0, max_strafe_ff} + {1'b0, max_yaw_ff};

   always_comb begin
      cfg.gain_p  = gain_p_ff;
      cfg.gain_d  = gain_d_ff;
      cfg.max_yaw = max_yaw_ff;
      cfg.ok      = (max_total_ff != '0) && (max_strafe_ff != '0) &&
                    (gain_p_ff != '0) && (max_yaw_ff != '0) &&
                    (limit_sum <= max_total_ff) &&
                    ((polarity_ff == SIGN_POS) || (polarity_ff == SIGN_NEG));
   end

endmodule

FILE: rtl/hhpd_pd.sv
module hhpd_pd (
   input  hhpd_pkg::cfg_type                       cfg,
   input  logic signed [hhpd_pkg::ANGLE_W-1:0]     target,
   input  logic signed [hhpd_pkg::ANGLE_W-1:0]     heading,
   input  logic signed [hhpd_pkg::ANGLE_W-1:0]     yaw_rate,
   output logic signed [hhpd_pkg::PTERM_W-1:0]     p_term,
   output logic signed [hhpd_pkg::DTERM_W-1:0]     d_term,
   output logic signed [hhpd_pkg::CORR_W-1:0]      correction
);
   import hhpd_pkg::*;

   logic signed [ERR_W-1:0]  err;
   logic signed [PROD_W-1:0] p_prod;
   logic signed [PROD_W-1:0] d_prod;
   logic signed [SUM_W-1:0]  p_full;
   logic signed [SUM_W-1:0]  d_full;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  lim_hi;
   logic signed [SUM_W-1:0]  lim_lo;

   assign err = ERR_W'(target) - ERR_W'(heading);

   // Arithmetic shift floors toward minus infinity
   assign p_prod = PROD_W'(signed'({1'b0, cfg.gain_p})) * PROD_W'(err);
   assign d_prod = -(PROD_W'(signed'({1'b0, cfg.gain_d})) * PROD_W'(yaw_rate));
   assign p_full = SUM_W'(p_prod >>> 8);
   assign d_full = SUM_W'(d_prod >>> 8);
   assign sum    = p_full + d_full;
   assign lim_hi = SUM_W'({1'b0, cfg.max_yaw});
   assign lim_lo = -lim_hi;

   always_comb begin
      if (sum > lim_hi) begin
         correction = CORR_W'(lim_hi);
      end else if (sum < lim_lo) begin
         correction = CORR_W'(lim_lo);
      end else begin
         correction = CORR_W'(sum);
      end
   end

   assign p_term = p_full[PTERM_W-1:0];
   assign d_term = d_full[DTERM_W-1:0];

endmodule

FILE: rtl/heading_hold_pd_controller.sv
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | func, heading, yaw_rate, measure_ok, side,
//         |           |                     | now_ms, defer_ms, fault_code
// rsp     | out       | rsp_valid/rsp_stall | mode, reason, target, angle_error, active_ms,
//         |           |                     | strafe_on, direction, p/d terms, correction,
//         |           |                     | accepted, faulted
// csr     | in        | csr_write           | csr_index, csr_data
//
// The accepting edge loads the input register; once the response slot is free,
// the state update and PD math are registered into the response register.
// One item per cycle is sustained while rsp_stall is low; the mode/target/start-time
// registers update in the same cycle the result is registered, so the next item sees them.
// Synchronous active-high reset clears the mode state and both valid flags.
// A stalled response holds; req_stall rises only when the input stage is full
// and the response register cannot drain.
module heading_hold_pd_controller (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration
   input  logic                                    csr_write,
   input  logic [hhpd_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [hhpd_pkg::CSR_DAT_W-1:0]          csr_data,
   // request
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [2:0]                              req_func,
   input  logic signed [hhpd_pkg::ANGLE_W-1:0]     req_heading,
   input  logic signed [hhpd_pkg::ANGLE_W-1:0]     req_yaw_rate,
   input  logic                                    req_measure_ok,
   input  logic signed [1:0]                       req_side,
   input  logic [hhpd_pkg::TIME_W-1:0]             req_now_ms,
   input  logic [hhpd_pkg::TIME_W-1:0]             req_defer_ms,
   input  logic [2:0]                              req_fault_code,
   // response
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [1:0]                              rsp_mode,
   output logic [2:0]                              rsp_reason,
   output logic signed [hhpd_pkg::ANGLE_W-1:0]     rsp_target,
   output logic signed [hhpd_pkg::ERR_W-1:0]       rsp_angle_error,
   output logic [hhpd_pkg::ELAPSED_W-1:0]          rsp_active_ms,
   output logic                                    rsp_strafe_on,
   output logic signed [1:0]                       rsp_direction,
   output logic signed [hhpd_pkg::PTERM_W-1:0]     rsp_p_term,
   output logic signed [hhpd_pkg::DTERM_W-1:0]     rsp_d_term,
   output logic signed [hhpd_pkg::CORR_W-1:0]      rsp_correction,
   output logic                                    rsp_accepted,
   output logic                                    rsp_faulted
);
   import hhpd_pkg::*;

   cfg_type cfg;

   // input stage
   logic                        s1_vld_ff, s1_vld_in;
   logic [2:0]                  func_ff;
   logic signed [ANGLE_W-1:0]   heading_ff;
   logic signed [ANGLE_W-1:0]   yaw_rate_ff;
   logic                        meas_ok_ff;
   logic signed [1:0]           side_ff;
   logic [TIME_W-1:0]           now_ff;
   logic [TIME_W-1:0]           defer_ff;
   logic [2:0]                  code_ff;

   // controller state
   mode_type                    mode_ff, mode_in;
   reason_type                  reason_ff, reason_in;
   logic signed [ANGLE_W-1:0]   target_ff, target_in;
   logic signed [1:0]           dir_ff, dir_in;
   logic [TIME_W-1:0]           start_ff, start_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   mode_type                    rsp_mode_ff;
   reason_type                  rsp_reason_ff;
   logic signed [ANGLE_W-1:0]   rsp_target_ff;
   logic signed [ERR_W-1:0]     rsp_err_ff, err_out;
   logic [ELAPSED_W-1:0]        rsp_el_ff, el_out;
   logic signed [1:0]           rsp_dir_ff;
   logic signed [PTERM_W-1:0]   rsp_p_ff, p_out, p_calc;
   logic signed [DTERM_W-1:0]   rsp_d_ff, d_out, d_calc;
   logic signed [CORR_W-1:0]    rsp_corr_ff, corr_out, corr_calc;
   logic                        rsp_acc_ff, acc_out;

   logic                        take, advance, out_free;
   logic                        side_ok, upd_ok, upd_fail;
   logic [TIME_W-1:0]           since;

   hhpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hhpd_pd u_pd (
      .cfg        (cfg),
      .target     (target_ff),
      .heading    (heading_ff),
      .yaw_rate   (yaw_rate_ff),
      .p_term     (p_calc),
      .d_term     (d_calc),
      .correction (corr_calc)
   );

   // Handshake: the input stage drains whenever the response slot is free
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = s1_vld_ff && out_free;
   assign req_stall    = s1_vld_ff && !out_free;
   assign take         = req_valid && !req_stall;
   assign s1_vld_in    = take || (s1_vld_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign side_ok = (side_ff == SIGN_POS) || (side_ff == SIGN_NEG);
   assign upd_ok   = (mode_ff == MODE_ACTIVE) && cfg.ok && meas_ok_ff;
   assign upd_fail = (mode_ff == MODE_ACTIVE) && !(cfg.ok && meas_ok_ff);

   // Next state for the command held in the input stage
   always_comb begin
      mode_in   = mode_ff;
      reason_in = reason_ff;
      target_in = target_ff;
      dir_in    = dir_ff;
      start_in  = start_ff;
      acc_out   = 1'b0;
      case (func_type'(func_ff))
         FUNC_RESET: begin
            mode_in   = MODE_IDLE;
            reason_in = REASON_NONE;
            target_in = '0;
            dir_in    = '0;
            start_in  = '0;
         end
         FUNC_START: begin
            if (cfg.ok && meas_ok_ff && side_ok) begin
               mode_in   = MODE_ACTIVE;
               reason_in = REASON_NONE;
               target_in = heading_ff;
               dir_in    = side_ff;
               start_in  = now_ff;
               acc_out   = 1'b1;
            end else begin
               mode_in   = MODE_FAULT;
               reason_in = REASON_CONFIG;
               target_in = '0;
               dir_in    = '0;
               start_in  = '0;
            end
         end
         FUNC_UPDATE: begin
            if (upd_fail) begin
               mode_in   = MODE_FAULT;
               reason_in = cfg.ok ? REASON_MEASURE : REASON_CONFIG;
            end
         end
         FUNC_STOP: begin
            mode_in   = MODE_STOPPED;
            reason_in = REASON_NONE;
         end
         FUNC_DEFER: begin
            if ((mode_ff == MODE_ACTIVE) && (defer_ff != '0)) begin
               start_in = start_ff + defer_ff;
            end
         end
         FUNC_FAULT: begin
            mode_in = MODE_FAULT;
            if ((code_ff == REASON_NONE) || (code_ff > REASON_COMMAND)) begin
               reason_in = REASON_MEASURE;
            end else begin
               reason_in = reason_type'(code_ff);
            end
         end
         default: ;
      endcase
   end

   // Result fields after the step; a failed update still reports elapsed time
   assign since   = now_ff - start_in;
   assign err_out = ERR_W'(target_in) - ERR_W'(heading_ff);

   always_comb begin
      if (((mode_in == MODE_ACTIVE) || (func_ff == FUNC_UPDATE && upd_fail)) &&
          !since[TIME_W-1]) begin
         el_out = since[ELAPSED_W-1:0];
      end else begin
         el_out = '0;
      end
      if ((func_ff == FUNC_UPDATE) && upd_ok) begin
         p_out    = p_calc;
         d_out    = d_calc;
         corr_out = corr_calc;
      end else begin
         p_out    = '0;
         d_out    = '0;
         corr_out = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         reason_ff    <= REASON_NONE;
         target_ff    <= '0;
         dir_ff       <= '0;
         start_ff     <= '0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff   <= mode_in;
            reason_ff <= reason_in;
            target_ff <= target_in;
            dir_ff    <= dir_in;
            start_ff  <= start_in;
         end
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (take) begin
         func_ff     <= req_func;
         heading_ff  <= req_heading;
         yaw_rate_ff <= req_yaw_rate;
         meas_ok_ff  <= req_measure_ok;
         side_ff     <= req_side;
         now_ff      <= req_now_ms;
         defer_ff    <= req_defer_ms;
         code_ff     <= req_fault_code;
      end
   end

   // Load the response register; hold it while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mode_ff   <= mode_in;
         rsp_reason_ff <= reason_in;
         rsp_target_ff <= target_in;
         rsp_err_ff    <= err_out;
         rsp_el_ff     <= el_out;
         rsp_dir_ff    <= dir_in;
         rsp_p_ff      <= p_out;
         rsp_d_ff      <= d_out;
         rsp_corr_ff   <= corr_out;
         rsp_acc_ff    <= acc_out;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mode        = rsp_mode_ff;
   assign rsp_reason      = rsp_reason_ff;
   assign rsp_target      = rsp_target_ff;
   assign rsp_angle_error = rsp_err_ff;
   assign rsp_active_ms   = rsp_el_ff;
   assign rsp_strafe_on   = (rsp_mode_ff == MODE_ACTIVE);
   assign rsp_direction   = rsp_dir_ff;
   assign rsp_p_term      = rsp_p_ff;
   assign rsp_d_term      = rsp_d_ff;
   assign rsp_correction  = rsp_corr_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_faulted     = (rsp_mode_ff == MODE_FAULT);

`ifndef ASSERT_OFF
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff)
      else $error("request stalled with an empty input stage");

   a_active_no_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_strafe_on |-> rsp_reason == REASON_NONE)
      else $error("active mode reported with a fault reason");

   a_idle_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == MODE_IDLE) |-> (rsp_target == '0) && (rsp_direction == '0))
      else $error("idle mode with latched target or direction");

   a_accept_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_strafe_on && (rsp_correction == '0))
      else $error("accepted start without active mode");

   a_state_moves_with_item: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(mode_ff) && $stable(start_ff))
      else $error("controller state changed without an item");
`endif

endmodule
